FILE: sv/widest_path_min_over_nodes_assert.svh
// assertion macros for the widest path engine
`ifndef WIDEST_PATH_MIN_OVER_NODES_ASSERT_SVH
`define WIDEST_PATH_MIN_OVER_NODES_ASSERT_SVH

// condition implies consequence in the same cycle
`define WPMN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define WPMN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/wpmn_pkg.sv
// shared types and constants of the widest path engine
package wpmn_pkg;
	localparam int DEF_MAX_NODES  = 1024;
	localparam int DEF_MAX_EDGES  = 4096;
	localparam int DEF_WIDTH_BITS = 32;
	localparam int NODE_W = 10;
	localparam int CNT_W  = 11;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_SOLVE = 2'd2,
		REQ_RSVD  = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_SINGLE   = 2'd1,
		ST_UNREACH  = 2'd2,
		ST_OVERFLOW = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ADD,
		OP_SOLVE,
		OP_WIPE,
		OP_SEED,
		OP_EDGE_RD,
		OP_NODE_A,
		OP_NODE_B,
		OP_CALC,
		OP_WR_A,
		OP_WR_B,
		OP_PASS,
		OP_SCAN_INIT,
		OP_SCAN_RD,
		OP_SCAN_CK
	} op_t;

	typedef enum logic [1:0] {
		REP_NONE,
		REP_OVF,
		REP_SINGLE,
		REP_SCAN
	} rep_t;

	typedef struct packed {
		op_t  op;
		rep_t rep;
	} dp_cmd_t;

	typedef struct packed {
		logic overflow;
		logic single;
		logic wipe_last;
		logic edge_none;
		logic edge_last;
		logic changed;
		logic scan_last;
	} dp_stat_t;
endpackage

FILE: sv/wpmn_ram.sv
// generic single write port ram with registered read
module wpmn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/wpmn_ctrl.sv
// sequencer of the widest path engine
module wpmn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [wpmn_pkg::REQ_W-1:0] req_type,
	input  wpmn_pkg::dp_stat_t st,
	output wpmn_pkg::dp_cmd_t cmd,
	output logic              busy
);
	import wpmn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_WIPE, S_SEED, S_E_RD, S_E_A, S_E_B, S_E_CALC, S_E_WA, S_E_WB,
		S_P_END, S_SC_INIT, S_SC_RD, S_SC_CK, S_SC_REP
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		cmd.rep = REP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req_t'(req_type))
						REQ_CLEAR: cmd.op = OP_CLEAR;
						REQ_ADD:   cmd.op = OP_ADD;
						REQ_SOLVE: begin
							if (st.overflow) begin
								cmd.rep = REP_OVF;
							end else if (st.single) begin
								cmd.rep = REP_SINGLE;
							end else begin
								cmd.op  = OP_SOLVE;
								state_d = S_WIPE;
							end
						end
						default: cmd.op = OP_NONE;
					endcase
				end
			end
			S_WIPE: begin
				cmd.op = OP_WIPE;
				if (st.wipe_last) state_d = S_SEED;
			end
			S_SEED: begin
				cmd.op  = OP_SEED;
				state_d = st.edge_none ? S_SC_INIT : S_E_RD;
			end
			S_E_RD: begin
				cmd.op  = OP_EDGE_RD;
				state_d = S_E_A;
			end
			S_E_A: begin
				cmd.op  = OP_NODE_A;
				state_d = S_E_B;
			end
			S_E_B: begin
				cmd.op  = OP_NODE_B;
				state_d = S_E_CALC;
			end
			S_E_CALC: begin
				cmd.op  = OP_CALC;
				state_d = S_E_WA;
			end
			S_E_WA: begin
				cmd.op  = OP_WR_A;
				state_d = S_E_WB;
			end
			S_E_WB: begin
				cmd.op  = OP_WR_B;
				state_d = st.edge_last ? S_P_END : S_E_RD;
			end
			S_P_END: begin
				if (st.changed) begin
					cmd.op  = OP_PASS;
					state_d = S_E_RD;
				end else begin
					state_d = S_SC_INIT;
				end
			end
			S_SC_INIT: begin
				cmd.op  = OP_SCAN_INIT;
				state_d = S_SC_RD;
			end
			S_SC_RD: begin
				cmd.op  = OP_SCAN_RD;
				state_d = S_SC_CK;
			end
			S_SC_CK: begin
				cmd.op  = OP_SCAN_CK;
				state_d = st.scan_last ? S_SC_REP : S_SC_RD;
			end
			S_SC_REP: begin
				cmd.rep = REP_SCAN;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;
endmodule

FILE: sv/wpmn_dp.sv
// edge store, node table and relaxation datapath
module wpmn_dp #(
	parameter int MAX_NODES  = wpmn_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES  = wpmn_pkg::DEF_MAX_EDGES,
	parameter int WIDTH_BITS = wpmn_pkg::DEF_WIDTH_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wpmn_pkg::dp_cmd_t             cmd,
	output wpmn_pkg::dp_stat_t            st,
	input  logic [wpmn_pkg::NODE_W-1:0]   node_a,
	input  logic [wpmn_pkg::NODE_W-1:0]   node_b,
	input  logic signed [WIDTH_BITS-1:0]  edge_width,
	input  logic                          cfg_wr_en,
	input  logic [wpmn_pkg::CNT_W-1:0]    cfg_wr_data,
	output logic                          done,
	output logic [wpmn_pkg::STAT_W-1:0]   status,
	output logic signed [WIDTH_BITS-1:0]  bottleneck
);
	import wpmn_pkg::*;

	localparam int NW   = $clog2(MAX_NODES);
	localparam int NCB  = $clog2(MAX_NODES + 1);
	localparam int CW   = (NCB > CNT_W) ? NCB : CNT_W;
	localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int TW   = $clog2(MAX_EDGES + 1);
	localparam int EDW  = 2 * NW + WIDTH_BITS;
	localparam int NDW  = WIDTH_BITS + 1;

	logic [CNT_W-1:0] ncnt_q;
	logic [CW-1:0]    nc_ext, eff;
	logic [TW-1:0]    total_q, eidx_q;
	logic             ovf_q, changed_q;
	logic [CW-1:0]    nidx_q;

	logic             e_we;
	logic [EDW-1:0]   e_wdata, e_rdata;
	logic [NW-1:0]    e_a, e_b;
	logic signed [WIDTH_BITS-1:0] e_k;

	logic             n_we;
	logic [NW-1:0]    n_waddr, n_raddr;
	logic [NDW-1:0]   n_wdata, n_rdata;
	logic             n_r;
	logic signed [WIDTH_BITS-1:0] n_w;

	logic [NW-1:0]    ea_q, eb_q;
	logic signed [WIDTH_BITS-1:0] ek_q, wa_q, ca_q, cb_q, least_q;
	logic             eskip_q, ra_q, upd_a_q, upd_b_q;
	logic             first_q, unreach_q;

	logic [CW-1:0]    a_ext, b_ext;
	logic signed [WIDTH_BITS-1:0] cand_ab, cand_ba;
	logic             upd_a, upd_b;

	logic             done_q;
	logic [STAT_W-1:0] status_q;
	logic signed [WIDTH_BITS-1:0] bneck_q;

	assign nc_ext = CW'(ncnt_q);
	assign eff    = (nc_ext == '0) ? CW'(1) :
	                (nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext;
	assign a_ext  = CW'(node_a);
	assign b_ext  = CW'(node_b);

	assign e_we    = (cmd.op == OP_ADD) && (a_ext < eff) && (b_ext < eff) &&
	                 (total_q != TW'(MAX_EDGES));
	assign e_wdata = {a_ext[NW-1:0], b_ext[NW-1:0], edge_width};
	assign e_a     = e_rdata[EDW-1 -: NW];
	assign e_b     = e_rdata[WIDTH_BITS+NW-1 -: NW];
	assign e_k     = e_rdata[WIDTH_BITS-1:0];

	wpmn_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edges (
		.clk   (clk),
		.we    (e_we),
		.waddr (total_q[EAW-1:0]),
		.wdata (e_wdata),
		.raddr (eidx_q[EAW-1:0]),
		.rdata (e_rdata)
	);

	assign n_r = n_rdata[NDW-1];
	assign n_w = n_rdata[WIDTH_BITS-1:0];

	always_comb begin
		n_we    = 1'b0;
		n_waddr = nidx_q[NW-1:0];
		n_wdata = '0;
		case (cmd.op)
			OP_WIPE: n_we = 1'b1;
			OP_SEED: begin
				n_we    = 1'b1;
				n_waddr = '0;
				n_wdata = {1'b1, {WIDTH_BITS{1'b0}}};
			end
			OP_WR_A: begin
				n_we    = upd_a_q;
				n_waddr = ea_q;
				n_wdata = {1'b1, ca_q};
			end
			OP_WR_B: begin
				n_we    = upd_b_q;
				n_waddr = eb_q;
				n_wdata = {1'b1, cb_q};
			end
			default: n_we = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_NODE_A:  n_raddr = e_a;
			OP_SCAN_RD: n_raddr = nidx_q[NW-1:0];
			default:    n_raddr = eb_q;
		endcase
	end

	wpmn_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_nodes (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	// both directions of one edge from the values read before either write
	assign cand_ab = ((ea_q != '0) && (wa_q < ek_q)) ? wa_q : ek_q;
	assign cand_ba = ((eb_q != '0) && (n_w < ek_q)) ? n_w : ek_q;
	assign upd_b   = !eskip_q && ra_q && (eb_q != '0) && (!n_r || (cand_ab > n_w));
	assign upd_a   = !eskip_q && n_r && (ea_q != '0) && (!ra_q || (cand_ba > wa_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncnt_q    <= CNT_W'(1);
			total_q   <= '0;
			ovf_q     <= 1'b0;
			eidx_q    <= '0;
			nidx_q    <= '0;
			changed_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) ncnt_q <= cfg_wr_data;
			done_q <= (cmd.rep != REP_NONE);
			case (cmd.op)
				OP_CLEAR: begin
					total_q <= '0;
					ovf_q   <= 1'b0;
				end
				OP_ADD: begin
					if (e_we) begin
						total_q <= total_q + 1'b1;
					end else if ((a_ext < eff) && (b_ext < eff)) begin
						ovf_q <= 1'b1;
					end
				end
				OP_SOLVE: nidx_q <= '0;
				OP_WIPE:  nidx_q <= nidx_q + 1'b1;
				OP_SEED: begin
					eidx_q    <= '0;
					changed_q <= 1'b0;
				end
				OP_WR_A: changed_q <= changed_q | upd_a_q;
				OP_WR_B: begin
					changed_q <= changed_q | upd_b_q;
					eidx_q    <= eidx_q + 1'b1;
				end
				OP_PASS: begin
					eidx_q    <= '0;
					changed_q <= 1'b0;
				end
				OP_SCAN_INIT: nidx_q <= CW'(1);
				OP_SCAN_CK:   nidx_q <= nidx_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_NODE_A: begin
				ea_q    <= e_a;
				eb_q    <= e_b;
				ek_q    <= e_k;
				eskip_q <= (CW'(e_a) >= eff) || (CW'(e_b) >= eff);
			end
			OP_NODE_B: begin
				ra_q <= n_r;
				wa_q <= n_w;
			end
			OP_CALC: begin
				upd_a_q <= upd_a;
				upd_b_q <= upd_b;
				ca_q    <= cand_ba;
				cb_q    <= cand_ab;
			end
			OP_SCAN_INIT: begin
				first_q   <= 1'b1;
				unreach_q <= 1'b0;
			end
			OP_SCAN_CK: begin
				if (!n_r) begin
					unreach_q <= 1'b1;
				end else if (first_q || (n_w < least_q)) begin
					least_q <= n_w;
				end
				first_q <= 1'b0;
			end
			default: ;
		endcase
		case (cmd.rep)
			REP_OVF: begin
				status_q <= ST_OVERFLOW;
				bneck_q  <= '0;
			end
			REP_SINGLE: begin
				status_q <= ST_SINGLE;
				bneck_q  <= '0;
			end
			REP_SCAN: begin
				status_q <= unreach_q ? ST_UNREACH : ST_OK;
				bneck_q  <= unreach_q ? '0 : least_q;
			end
			default: ;
		endcase
	end

	assign st.overflow  = ovf_q;
	assign st.single    = (eff == CW'(1));
	assign st.wipe_last = (nidx_q == eff - 1'b1);
	assign st.edge_none = (total_q == '0);
	assign st.edge_last = (TW'(eidx_q + 1'b1) == total_q);
	assign st.changed   = changed_q;
	assign st.scan_last = (nidx_q == eff - 1'b1);

	assign done       = done_q;
	assign status     = status_q;
	assign bottleneck = bneck_q;
endmodule

FILE: sv/widest_path_min_over_nodes.sv
// top level of the widest path bottleneck engine
// Clear and add-edge beats never raise busy, so they can be issued every cycle. A solve beat
// not reported at once raises busy: the node table (node_count entries) is first cleared one
// entry per cycle, then, if edges are stored, the edge store is swept repeatedly (edge read,
// two node reads, compute, two node writes) until a full sweep changes nothing, then nodes 1
// to n-1 are scanned; the result appears for one cycle on done the cycle busy falls. Overflow
// and single-node solves report on the cycle after the beat. Results cannot be stalled.
module widest_path_min_over_nodes #(
	parameter int MAX_NODES  = wpmn_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES  = wpmn_pkg::DEF_MAX_EDGES,
	parameter int WIDTH_BITS = wpmn_pkg::DEF_WIDTH_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [wpmn_pkg::REQ_W-1:0]    req_type,
	input  logic [wpmn_pkg::NODE_W-1:0]   node_a,
	input  logic [wpmn_pkg::NODE_W-1:0]   node_b,
	input  logic signed [WIDTH_BITS-1:0]  edge_width,
	input  logic                          cfg_wr_en,
	input  logic [wpmn_pkg::CNT_W-1:0]    cfg_wr_data,
	output logic                          done,
	output logic [wpmn_pkg::STAT_W-1:0]   status,
	output logic signed [WIDTH_BITS-1:0]  bottleneck
);
	import wpmn_pkg::*;
	`include "widest_path_min_over_nodes_assert.svh"

	dp_cmd_t  cmd;
	dp_stat_t st;

	wpmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	wpmn_dp #(
		.MAX_NODES  (MAX_NODES),
		.MAX_EDGES  (MAX_EDGES),
		.WIDTH_BITS (WIDTH_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.node_a      (node_a),
		.node_b      (node_b),
		.edge_width  (edge_width),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.status      (status),
		.bottleneck  (bottleneck)
	);

	`WPMN_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")
	`WPMN_ASSERT_NOW(a_fall_done, $fell(busy), done, "solve ended without a result")
	`WPMN_ASSERT_NEXT(a_solve_resp, start && !busy && (req_type == REQ_SOLVE), busy || done,
		"solve beat neither started work nor reported")
endmodule

FILE: sim/tb.sv
// testbench for the widest path bottleneck engine: directed table, an edge store overflow fill, then random graphs
module tb;
	import wpmn_pkg::*;

	localparam int NMAX  = DEF_MAX_NODES;
	localparam int EMAX  = DEF_MAX_EDGES;
	localparam int LIMIT = 6000000;
	localparam bit K_ITEM = 1'b0;
	localparam bit K_CFG  = 1'b1;

	typedef struct {
		bit                 kind;
		req_t               req;
		int                 a;
		int                 b;
		logic signed [31:0] w;
		bit                 typed;
		stat_t              st;
		logic signed [31:0] bn;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [REQ_W-1:0]    req_type = '0;
	logic [NODE_W-1:0]   node_a = '0;
	logic [NODE_W-1:0]   node_b = '0;
	logic signed [31:0]  edge_width = '0;
	logic                cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]    cfg_wr_data = '0;
	logic                done;
	logic [STAT_W-1:0]   status;
	logic signed [31:0]  bottleneck;

	widest_path_min_over_nodes u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .node_a(node_a), .node_b(node_b), .edge_width(edge_width),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.done(done), .status(status), .bottleneck(bottleneck)
	);

	always #5 clk = ~clk;

	// graph mirror
	int                 g_a[$];
	int                 g_b[$];
	logic signed [31:0] g_w[$];
	bit                 g_ovf;
	int                 g_cnt;
	logic signed [31:0] widest[NMAX];
	bit                 seen[NMAX];

	stat_t              want_st[$];
	logic signed [31:0] want_bn[$];
	int                 errors = 0;
	int                 cycles = 0;
	int                 items = 0;
	bit                 quiet = 1'b0;

	function automatic int live_nodes();
		if (g_cnt == 0) return 1;
		if (g_cnt > NMAX) return NMAX;
		return g_cnt;
	endfunction

	function automatic bit widen(int u, int v, logic signed [31:0] w);
		logic signed [31:0] cand;
		if (!seen[u] || v == 0) return 1'b0;
		cand = w;
		if (u != 0 && widest[u] < cand) cand = widest[u];
		if (!seen[v] || cand > widest[v]) begin
			seen[v] = 1'b1;
			widest[v] = cand;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void solve_graph(output stat_t st, output logic signed [31:0] bn);
		int n;
		bit moved;
		n = live_nodes();
		bn = '0;
		if (g_ovf) begin
			st = ST_OVERFLOW;
			return;
		end
		if (n == 1) begin
			st = ST_SINGLE;
			return;
		end
		for (int i = 0; i < NMAX; i++) seen[i] = 1'b0;
		seen[0] = 1'b1;
		do begin
			moved = 1'b0;
			foreach (g_a[i]) begin
				if (g_a[i] < n && g_b[i] < n) begin
					moved |= widen(g_a[i], g_b[i], g_w[i]);
					moved |= widen(g_b[i], g_a[i], g_w[i]);
				end
			end
		end while (moved);
		for (int i = 1; i < n; i++) begin
			if (!seen[i]) begin
				st = ST_UNREACH;
				bn = '0;
				return;
			end
			if (i == 1 || widest[i] < bn) bn = widest[i];
		end
		st = ST_OK;
	endfunction

	// returns 1 when a result is due
	function automatic bit apply_beat(req_t r, int a, int b, logic signed [31:0] w,
			output stat_t st, output logic signed [31:0] bn);
		int n;
		n = live_nodes();
		st = ST_OK;
		bn = '0;
		case (r)
			REQ_CLEAR: begin
				g_a.delete();
				g_b.delete();
				g_w.delete();
				g_ovf = 1'b0;
			end
			REQ_ADD: begin
				if (a < n && b < n) begin
					if (g_a.size() >= EMAX) g_ovf = 1'b1;
					else begin
						g_a = {g_a, a};
						g_b = {g_b, b};
						g_w = {g_w, w};
					end
				end
			end
			REQ_SOLVE: begin
				solve_graph(st, bn);
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send(req_t r, int a, int b, logic signed [31:0] w,
			bit typed = 1'b0, stat_t tst = ST_OK, logic signed [31:0] tbn = '0);
		stat_t st;
		logic signed [31:0] bn;
		if (!quiet && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= r;
		node_a <= a[NODE_W-1:0];
		node_b <= b[NODE_W-1:0];
		edge_width <= w;
		do @(posedge clk); while (busy);
		if (apply_beat(r, a, b, w, st, bn)) begin
			want_st = {want_st, (typed ? tst : st)};
			want_bn = {want_bn, (typed ? tbn : bn)};
		end
		if (r != REQ_RSVD) items++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (want_st.size() > 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_nodes(int v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v[CNT_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		g_cnt = v;
	endtask

	function automatic logic signed [31:0] pick_width();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (want_st.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat: status %0d bottleneck %h",
					status, bottleneck);
			end else begin
				if (status !== want_st[0] || bottleneck !== want_bn[0]) begin
					errors++;
					if (errors <= 10)
						$display("result mismatch: status exp %0d got %0d, bottleneck exp %h got %h",
							want_st[0], status, want_bn[0], bottleneck);
				end
				void'(want_st.pop_front());
				void'(want_bn.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("widest_path_min_over_nodes: mismatch");
			$finish;
		end
	end

	initial begin
		row_t tab[25];
		int n, k, a, b;
		tab = '{
			'{K_ITEM, REQ_SOLVE, 0, 0, 0, 1, ST_SINGLE, 0},
			'{K_CFG, REQ_CLEAR, 2, 0, 0, 0, ST_OK, 0},
			'{K_ITEM, REQ_SOLVE, 0, 0, 0, 1, ST_UNREACH, 0},
			'{K_ITEM, REQ_ADD, 0, 1, 32'sh7fffffff, 0, ST_OK, 0},
			'{K_ITEM, REQ_SOLVE, 0, 0, 0, 1, ST_OK, 32'sh7fffffff},
			'{K_ITEM, REQ_CLEAR, 0, 0, 0, 0, ST_OK, 0},
			'{K_ITEM, REQ_ADD, 1, 0, 32'sh80000000, 0, ST_OK, 0},
			'{K_ITEM, REQ_SOLVE, 0, 0, 0, 1, ST_OK, 32'sh80000000},
			'{K_ITEM, REQ_ADD, 0, 1, 5, 0, ST_OK, 0},
			'{K_ITEM, REQ_ADD, 0, 0, 32'sh7fffffff, 0, ST_OK, 0},
			'{K_ITEM, REQ_ADD, 1, 1, 32'sh7fffffff, 0, ST_OK, 0},
			'{K_ITEM, REQ_ADD, 1, 2, 32'sh7fffffff, 0, ST_OK, 0},
			'{K_ITEM, REQ_RSVD, 1023, 1023, -1, 0, ST_OK, 0},
			'{K_ITEM, REQ_SOLVE, 0, 0, 0, 0, ST_OK, 0},
			'{K_CFG, REQ_CLEAR, 0, 0, 0, 0, ST_OK, 0},
			'{K_ITEM, REQ_SOLVE, 0, 0, 0, 1, ST_SINGLE, 0},
			'{K_CFG, REQ_CLEAR, 2047, 0, 0, 0, ST_OK, 0},
			'{K_ITEM, REQ_SOLVE, 0, 0, 0, 1, ST_UNREACH, 0},
			'{K_CFG, REQ_CLEAR, 3, 0, 0, 0, ST_OK, 0},
			'{K_ITEM, REQ_CLEAR, 0, 0, 0, 0, ST_OK, 0},
			'{K_ITEM, REQ_ADD, 0, 1, 10, 0, ST_OK, 0},
			'{K_ITEM, REQ_ADD, 1, 2, 20, 0, ST_OK, 0},
			'{K_ITEM, REQ_ADD, 0, 2, 3, 0, ST_OK, 0},
			'{K_ITEM, REQ_ADD, 1023, 1023, -1, 0, ST_OK, 0},
			'{K_ITEM, REQ_SOLVE, 0, 0, 0, 0, ST_OK, 0}
		};
		g_ovf = 1'b0;
		g_cnt = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tab[i]) begin
			if (tab[i].kind == K_CFG) set_nodes(tab[i].a);
			else send(tab[i].req, tab[i].a, tab[i].b, tab[i].w, tab[i].typed, tab[i].st,
				tab[i].bn);
		end

		// fill the edge store past its end
		set_nodes(2);
		send(REQ_CLEAR, 0, 0, 0);
		quiet = 1'b1;
		for (int i = 0; i <= EMAX; i++) send(REQ_ADD, i & 1, 1, $urandom);
		quiet = 1'b0;
		send(REQ_SOLVE, 0, 0, 0, 1'b1, ST_OVERFLOW, 0);
		send(REQ_CLEAR, 0, 0, 0);
		send(REQ_SOLVE, 0, 0, 0, 1'b1, ST_UNREACH, 0);
		items = 0;

		while (items < 1700) begin
			quiet = (items > 600 && items < 900);
			case ($urandom_range(0, 19))
				0: n = 0;
				1: n = 1;
				2: n = 1024;
				3: n = $urandom_range(1025, 2047);
				4: n = $urandom_range(11, 1023);
				default: n = $urandom_range(2, 10);
			endcase
			set_nodes(n);
			n = live_nodes();
			if ($urandom_range(0, 9) != 0) send(REQ_CLEAR, 0, 0, 0);
			repeat ($urandom_range(1, 3)) begin
				k = $urandom_range(0, (n > 13) ? 40 : 3 * n);
				repeat (k) begin
					if ($urandom_range(0, 9) == 0) begin
						a = $urandom_range(0, 1023);
						b = $urandom_range(0, 1023);
					end else begin
						a = $urandom_range(0, n - 1);
						b = $urandom_range(0, n - 1);
					end
					if ($urandom_range(0, 29) == 0) send(REQ_RSVD, a, b, $urandom);
					else send(REQ_ADD, a, b, pick_width());
				end
				send(REQ_SOLVE, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && want_st.size() == 0) begin
			$display("widest_path_min_over_nodes: match");
		end else begin
			$display("widest_path_min_over_nodes: mismatch");
		end
		$finish;
	end
endmodule

FILE: widest_path_min_over_nodes.f
+incdir+sv
sv/wpmn_pkg.sv
sv/wpmn_ram.sv
sv/wpmn_ctrl.sv
sv/wpmn_dp.sv
sv/widest_path_min_over_nodes.sv
sim/tb.sv
